/* rtl/mts_pkg.sv */
// mts_pkg: shared constants, codes and controller command type for the
// max tracking stack. No dependencies.
`default_nettype none
package mts_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_POP_EMPTY = 2'd1;
    localparam status_t STATUS_PUSH_FULL = 2'd2;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted request
        logic commit;   // apply the request and load the result register
    } mts_cmd_t;

endpackage
`default_nettype wire

/* rtl/max_tracking_stack_unit.sv */
// max_tracking_stack_unit: top level of the max tracking stack.
// Depends on mts_pkg, mts_ctrl, mts_dp and mts_ram.
`default_nettype none
// A LIFO of signed 32-bit values that reports its current maximum with every
// result. Each request is a push or a pop and returns one result: the popped
// value, the maximum held after the operation with a valid flag, a status
// (ok, pop on empty, push on full) and the fill level. One request is in work
// at a time and goes from acceptance to result in these steps: the acceptance
// cycle, in which the value and auxiliary RAMs are read at the current stack
// pointers, and the commit cycle, which uses the registered read data. The
// commit waits while an earlier result still sits unread in the output
// register. No clearing pass follows reset; the block is ready at once.
module max_tracking_stack_unit
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_action,
    input  wire logic signed [DATA_W-1:0]                s_push_value,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed      [DATA_W-1:0]                m_pop_value,
    output logic signed      [DATA_W-1:0]                m_max_value,
    output logic                                         m_max_valid,
    output logic             [STATUS_W-1:0]              m_status,
    output logic             [$clog2(STACK_DEPTH+1)-1:0] m_fill_count
);

    mts_cmd_t cmd;

    mts_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd)
    );

    mts_dp #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_action     (s_action),
        .in_push_value (s_push_value),
        .out_pop_value (m_pop_value),
        .out_max_value (m_max_value),
        .out_max_valid (m_max_valid),
        .out_status    (m_status),
        .out_fill_count(m_fill_count)
    );

endmodule
`default_nettype wire

/* rtl/mts_ram.sv */
// mts_ram: generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/mts_ctrl.sv */
// mts_ctrl: request sequencer and result handshake for the max tracking stack.
// Depends on mts_pkg.
`default_nettype none
module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output mts_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // read data is back; wait only for room in the result register
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/mts_dp.sv */
// mts_dp: value stack, auxiliary (max, repeat count) stack and result register.
// Depends on mts_pkg and mts_ram.
`default_nettype none
module mts_dp
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire mts_cmd_t                         cmd,
    input  wire logic                             in_action,
    input  wire logic signed [DATA_W-1:0]         in_push_value,
    output logic signed      [DATA_W-1:0]         out_pop_value,
    output logic signed      [DATA_W-1:0]         out_max_value,
    output logic                                  out_max_valid,
    output status_t                               out_status,
    output logic             [$clog2(STACK_DEPTH+1)-1:0] out_fill_count
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int AUX_W = DATA_W + CW;

    // stack pointers and cached top pair of the auxiliary stack
    logic        [CW-1:0]     value_top_reg, value_top_next;
    logic        [CW-1:0]     max_top_reg, max_top_next;
    logic signed [DATA_W-1:0] top_max_reg, top_max_next;
    logic        [CW-1:0]     top_cnt_reg, top_cnt_next;

    logic                     action_reg;
    logic signed [DATA_W-1:0] push_value_reg;

    logic signed [DATA_W-1:0] pop_value_reg, max_value_reg;
    logic                     max_valid_reg;
    status_t                  status_reg;
    logic        [CW-1:0]     fill_reg;

    logic                     val_wr_en;
    logic        [AW-1:0]     val_wr_addr, val_rd_addr;
    logic signed [DATA_W-1:0] val_rd_data;
    logic                     aux_wr_en;
    logic        [AW-1:0]     aux_wr_addr, aux_rd_addr;
    logic        [AUX_W-1:0]  aux_rd_data;
    logic        [CW-1:0]     vt_dec, mt_dec, mt_dec2, cnt_dec;
    logic                     stack_full, stack_empty, push_ok, pop_ok;
    status_t                  status_next;
    logic signed [DATA_W-1:0] pop_value_next;

    assign vt_dec  = value_top_reg - CW'(1);
    assign mt_dec  = max_top_reg - CW'(1);
    assign mt_dec2 = max_top_reg - CW'(2);
    assign cnt_dec = (top_cnt_reg != '0) ? top_cnt_reg - CW'(1) : '0;

    // reads follow the pointers, so data is ready in the cycle after the request
    assign val_rd_addr = vt_dec[AW-1:0];
    assign aux_rd_addr = mt_dec2[AW-1:0];
    assign val_wr_addr = value_top_reg[AW-1:0];
    assign aux_wr_addr = mt_dec[AW-1:0];

    assign stack_full  = (value_top_reg == CW'(STACK_DEPTH));
    assign stack_empty = (value_top_reg == '0);
    assign push_ok     = (action_reg == ACTION_PUSH) && !stack_full;
    assign pop_ok      = (action_reg == ACTION_POP) && !stack_empty;

    mts_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_value_ram (
        .aclk   (aclk),
        .wr_en  (val_wr_en),
        .wr_addr(val_wr_addr),
        .wr_data(push_value_reg),
        .rd_addr(val_rd_addr),
        .rd_data(val_rd_data)
    );

    // holds the pairs below the cached top pair
    mts_ram #(
        .WIDTH(AUX_W),
        .DEPTH(STACK_DEPTH)
    ) u_aux_ram (
        .aclk   (aclk),
        .wr_en  (aux_wr_en),
        .wr_addr(aux_wr_addr),
        .wr_data({top_max_reg, top_cnt_reg}),
        .rd_addr(aux_rd_addr),
        .rd_data(aux_rd_data)
    );

    always_comb begin
        value_top_next = value_top_reg;
        max_top_next   = max_top_reg;
        top_max_next   = top_max_reg;
        top_cnt_next   = top_cnt_reg;
        val_wr_en      = 1'b0;
        aux_wr_en      = 1'b0;
        pop_value_next = '0;
        status_next    = STATUS_OK;
        if (action_reg == ACTION_PUSH) begin
            if (stack_full) begin
                status_next = STATUS_PUSH_FULL;
            end else begin
                val_wr_en      = cmd.commit;
                value_top_next = value_top_reg + CW'(1);
                if (max_top_reg == '0) begin
                    top_max_next = push_value_reg;
                    top_cnt_next = CW'(1);
                    max_top_next = CW'(1);
                end else if (push_value_reg == top_max_reg) begin
                    top_cnt_next = top_cnt_reg + CW'(1);
                end else if (push_value_reg > top_max_reg &&
                             max_top_reg < CW'(STACK_DEPTH)) begin
                    // spill the old top pair and start a new one
                    aux_wr_en    = cmd.commit;
                    top_max_next = push_value_reg;
                    top_cnt_next = CW'(1);
                    max_top_next = max_top_reg + CW'(1);
                end
            end
        end else begin
            if (stack_empty) begin
                status_next = STATUS_POP_EMPTY;
            end else begin
                value_top_next = vt_dec;
                pop_value_next = val_rd_data;
                if (max_top_reg != '0 && val_rd_data == top_max_reg) begin
                    if (cnt_dec == '0) begin
                        max_top_next = mt_dec;
                        top_max_next = aux_rd_data[AUX_W-1:CW];
                        top_cnt_next = aux_rd_data[CW-1:0];
                    end else begin
                        top_cnt_next = cnt_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_top_reg <= '0;
            max_top_reg   <= '0;
        end else if (cmd.commit) begin
            value_top_reg <= value_top_next;
            max_top_reg   <= max_top_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg     <= in_action;
            push_value_reg <= in_push_value;
        end
        if (cmd.commit) begin
            top_max_reg   <= top_max_next;
            top_cnt_reg   <= top_cnt_next;
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
            fill_reg      <= value_top_next;
            if (value_top_next != '0 && max_top_next != '0) begin
                max_value_reg <= top_max_next;
                max_valid_reg <= 1'b1;
            end else begin
                max_value_reg <= '0;
                max_valid_reg <= 1'b0;
            end
        end
    end

    assign out_pop_value  = pop_value_reg;
    assign out_max_value  = max_value_reg;
    assign out_max_valid  = max_valid_reg;
    assign out_status     = status_reg;
    assign out_fill_count = fill_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        value_top_reg <= CW'(STACK_DEPTH))
        else $error("value stack pointer beyond depth");

    a_aux_not_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        max_top_reg <= value_top_reg)
        else $error("auxiliary stack deeper than value stack");

    a_aux_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (value_top_reg != '0) == (max_top_reg != '0))
        else $error("auxiliary stack out of step with value stack");

    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && !push_ok && !pop_ok |=>
            value_top_reg == $past(value_top_reg) && max_top_reg == $past(max_top_reg))
        else $error("rejected request changed the stacks");

endmodule
`default_nettype wire
